// ----- rtl/mst_pkg.sv -----
package mst_pkg;

   localparam int FEATURES = 16;
   localparam int HIDDEN   = 16;
   localparam int NWEIGHTS = FEATURES * HIDDEN + 2 * HIDDEN + 1;
   localparam int OFS_B0   = FEATURES * HIDDEN;
   localparam int OFS_W1   = OFS_B0 + HIDDEN;
   localparam int OFS_B1   = OFS_W1 + HIDDEN;

   localparam int FI_W  = (FEATURES > 1) ? $clog2(FEATURES) : 1;
   localparam int HI_W  = (HIDDEN > 1) ? $clog2(HIDDEN) : 1;
   localparam int FB_W  = $clog2(2 * FEATURES);
   localparam int HB_W  = $clog2(2 * HIDDEN);
   localparam int WA_W  = $clog2(NWEIGHTS);
   localparam int ACC_W = 16 + $clog2(((FEATURES > HIDDEN) ? FEATURES : HIDDEN) + 2);

   localparam logic signed [15:0] QONE = 16'sd4096;

   typedef logic signed [15:0] q_type;
   typedef logic [255:0][12:0] sig_rom_type;

   typedef enum logic [2:0] {
      MODE_FEATURE = 3'd0,
      MODE_WEIGHT  = 3'd1,
      MODE_NMIN    = 3'd2,
      MODE_NSCALE  = 3'd3,
      MODE_INFER   = 3'd4,
      MODE_POINT   = 3'd5,
      MODE_PAIR    = 3'd6
   } mode_type;

   typedef enum logic {
      CSR_THRESHOLD = 1'b0,
      CSR_NORM_EN   = 1'b1
   } csr_index_type;

   typedef enum logic [4:0] {
      S_IDLE, S_PRD, S_PNM, S_HB, S_HBL, S_HR, S_HM, S_HS,
      S_OB, S_OBL, S_OR, S_OM, S_OS, S_CP, S_CR,
      S_D1A, S_D1B, S_D0R, S_D0A, S_D0B, S_NR, S_NW
   } state_type;

   typedef enum logic [1:0] {
      NPH_B1, NPH_W1, NPH_B0, NPH_W0
   } nph_type;

   function automatic q_type sat16(input logic signed [39:0] v);
      if (v > 40'sd32767) return 16'sh7FFF;
      if (v < -40'sd32768) return 16'sh8000;
      return v[15:0];
   endfunction

   function automatic q_type qmul(input q_type a, input q_type b);
      logic signed [31:0] p;
      p = a * b;
      return sat16(40'(p >>> 12));
   endfunction

   // Restoring shift-subtract division for table setup: quotient in the upper half,
   // remainder in the lower half.
   function automatic logic [127:0] udivmod(input logic [63:0] n, input logic [63:0] d);
      logic [64:0] rem;
      logic [63:0] quo;
      rem = '0;
      quo = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[63:0], n[b]};
         if (rem >= {1'b0, d}) begin
            rem = rem - {1'b0, d};
            quo[b] = 1'b1;
         end
      end
      return {quo, rem[63:0]};
   endfunction

   // Logistic table: entry k = round(4096 / (1 + exp(-(k - 128) / 16))).
   function automatic sig_rom_type build_sig_rom();
      sig_rom_type rom;
      longint unsigned one, term, e, d, den, num, q, r, kk;
      logic [127:0] qr, qr2;
      rom = '0;
      one = 64'd1 << 40;
      for (int k = 0; k <= 128; k++) begin
         kk = longint'(k);
         term = one;
         e = one;
         for (int n = 1; n <= 96; n++) begin
            if (term != 0) begin
               d = 64'd16 * longint'(n);
               qr = udivmod(term, d);
               qr2 = udivmod(qr[63:0] * kk, d);
               term = qr[127:64] * kk + qr2[127:64];
               e = e + term;
            end
         end
         den = e + one;
         num = 64'd4096 * e;
         qr = udivmod(num, den);
         q = qr[127:64];
         r = qr[63:0];
         if (2 * r >= den) q = q + 1;
         if (k < 128) rom[128 + k] = 13'(q);
         if (k > 0) rom[128 - k] = 13'(64'd4096 - q);
      end
      return rom;
   endfunction

   localparam sig_rom_type SIG_ROM = build_sig_rom();

   function automatic logic [12:0] sig_lookup(input logic signed [ACC_W-1:0] x);
      q_type c;
      c = sat16(40'(x));
      return SIG_ROM[{~c[15], c[14:8]}];
   endfunction

endpackage

// ----- rtl/mlp_sigmoid_train_infer_top.sv -----
// One-hidden-layer sigmoid network in signed Q4.12 with in-place SGD training (learning rate 1).
// Issue a word with start while busy is low. Load words (feature, weight, norm min, norm
// scale) and the unused mode are handled in idle: the result strobe rsp_valid rises in the
// next cycle and busy stays low. Inference and training walk every weight through one shared
// 16x16 multiplier with a registered weight-memory read: pointwise training adds a backward
// pass to the forward pass, and pair training with differing labels runs two forward and two
// backward passes (with equal labels, only one forward pass). busy is high for the whole item.
// The result is shown on the rsp_ ports for exactly one cycle with rsp_valid and cannot be
// stalled: capture it then. The configuration port is always ready; write it only while
// busy is low and no word is in flight. Features and weights must be loaded before they are
// used.
module mlp_sigmoid_train_infer_top
   import mst_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_mode,
   input  logic               req_slot,
   input  logic [10:0]        req_index,
   input  logic signed [15:0] req_value,
   input  logic               req_label_a,
   input  logic               req_label_b,
   input  logic [14:0]        req_cost_weight,
   output logic               rsp_valid,
   output logic [12:0]        rsp_score,
   output logic               rsp_pred_class,
   output logic [14:0]        rsp_abs_cost,
   output logic               rsp_updated,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_index,
   input  logic [12:0]        csr_wdata
);

   // storage
   q_type fmem [2*FEATURES];
   q_type wmem [NWEIGHTS];
   q_type nmin_ff [FEATURES];
   q_type nrec_ff [FEATURES];
   q_type x_ff [2*FEATURES];
   q_type h_ff [2*HIDDEN];
   q_type d0_ff [HIDDEN];

   // control and datapath registers
   state_type state_ff, state_in;
   nph_type   nph_ff, nph_in;
   mode_type  mode_ff, mode_in;
   logic p_ff, p_in;
   logic [FI_W-1:0] i_ff, i_in;
   logic [HI_W-1:0] j_ff, j_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   q_type t_ff, t_in, d_ff, d_in, delta1_ff, delta1_in, c_ff, c_in;
   logic [12:0] oa_ff, oa_in, ob_ff, ob_in;
   logic changed_ff, changed_in, train_ff, train_in;
   logic la_ff, la_in, lb_ff, lb_in;
   logic [14:0] cw_ff, cw_in;
   logic [WA_W-1:0] waddr_ff;
   q_type f_rd_ff, w_rd_ff;
   logic [12:0] thr_ff;
   logic norm_en_ff;

   logic rsp_valid_ff, rsp_valid_in, rsp_pred_ff, rsp_pred_in, rsp_upd_ff, rsp_upd_in;
   logic [12:0] rsp_score_ff, rsp_score_in;
   logic [14:0] rsp_cost_ff, rsp_cost_in;

   // combinational controls
   q_type mul_a, mul_b, prod;
   logic [FB_W-1:0] fx, f_raddr, f_waddr;
   logic [HB_W-1:0] hx;
   logic [WA_W-1:0] w_raddr, w_waddr;
   logic f_we, w_we, x_we, h_we, d0_we, nmin_we, nrec_we, finish;
   q_type w_wdata, x_wdata, h_wdata, diff, nv, abs_c;
   logic signed [16:0] nsum;

   assign fx = FB_W'(p_ff) * FB_W'(FEATURES) + FB_W'(i_ff);
   assign hx = HB_W'(p_ff) * HB_W'(HIDDEN) + HB_W'(j_ff);
   assign prod = qmul(mul_a, mul_b);
   assign f_waddr = FB_W'(req_slot) * FB_W'(FEATURES) + FB_W'(req_index[FI_W-1:0]);
   assign w_waddr = w_we && (state_ff == S_IDLE) ? req_index[WA_W-1:0] : waddr_ff;
   assign f_raddr = fx;

   always_comb begin
      state_in = state_ff;   nph_in = nph_ff;       mode_in = mode_ff;
      p_in = p_ff;           i_in = i_ff;           j_in = j_ff;
      acc_in = acc_ff;       t_in = t_ff;           d_in = d_ff;
      delta1_in = delta1_ff; c_in = c_ff;           oa_in = oa_ff;
      ob_in = ob_ff;         changed_in = changed_ff; train_in = train_ff;
      la_in = la_ff;         lb_in = lb_ff;         cw_in = cw_ff;
      rsp_valid_in = 1'b0;   rsp_score_in = rsp_score_ff; rsp_pred_in = rsp_pred_ff;
      rsp_cost_in = rsp_cost_ff; rsp_upd_in = rsp_upd_ff;
      mul_a = '0; mul_b = '0;
      w_raddr = waddr_ff;
      f_we = 1'b0; w_we = 1'b0; x_we = 1'b0; h_we = 1'b0; d0_we = 1'b0;
      nmin_we = 1'b0; nrec_we = 1'b0; finish = 1'b0;
      w_wdata = req_value; x_wdata = '0; h_wdata = '0;
      diff = '0; nv = '0; nsum = '0; abs_c = '0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               mode_in = mode_type'(req_mode);
               la_in = req_label_a;
               lb_in = req_label_b;
               cw_in = req_cost_weight;
               p_in = 1'b0;
               i_in = '0;
               j_in = '0;
               changed_in = 1'b0;
               train_in = 1'b0;
               case (mode_type'(req_mode))
                  MODE_FEATURE: f_we = (req_index < 11'(FEATURES));
                  MODE_WEIGHT:  w_we = (req_index < 11'(NWEIGHTS));
                  MODE_NMIN:    nmin_we = (req_index < 11'(FEATURES));
                  MODE_NSCALE:  nrec_we = (req_index < 11'(FEATURES));
                  MODE_INFER, MODE_POINT, MODE_PAIR: state_in = S_PRD;
                  default: ;
               endcase
               if (state_in == S_IDLE) begin
                  rsp_valid_in = 1'b1;
                  rsp_score_in = '0;
                  rsp_pred_in = 1'b0;
                  rsp_cost_in = '0;
                  rsp_upd_in = 1'b0;
               end
            end
         end
         S_PRD: state_in = S_PNM;
         S_PNM: begin
            diff = sat16(40'(f_rd_ff) - 40'(nmin_ff[i_ff]));
            mul_a = diff;
            mul_b = nrec_ff[i_ff];
            x_we = 1'b1;
            x_wdata = norm_en_ff ? prod : f_rd_ff;
            if (i_ff == FI_W'(FEATURES - 1)) begin
               i_in = '0;
               j_in = '0;
               state_in = S_HB;
            end else begin
               i_in = i_ff + 1'b1;
               state_in = S_PRD;
            end
         end
         S_HB: begin
            w_raddr = WA_W'(OFS_B0) + WA_W'(j_ff);
            state_in = S_HBL;
         end
         S_HBL: begin
            acc_in = ACC_W'(w_rd_ff);
            i_in = '0;
            state_in = S_HR;
         end
         S_HR: begin
            w_raddr = WA_W'(i_ff) * WA_W'(HIDDEN) + WA_W'(j_ff);
            state_in = S_HM;
         end
         S_HM: begin
            mul_a = x_ff[fx];
            mul_b = w_rd_ff;
            acc_in = acc_ff + ACC_W'(prod);
            if (i_ff == FI_W'(FEATURES - 1)) begin
               state_in = S_HS;
            end else begin
               i_in = i_ff + 1'b1;
               state_in = S_HR;
            end
         end
         S_HS: begin
            h_we = 1'b1;
            h_wdata = 16'(sig_lookup(acc_ff));
            if (j_ff == HI_W'(HIDDEN - 1)) begin
               state_in = S_OB;
            end else begin
               j_in = j_ff + 1'b1;
               state_in = S_HB;
            end
         end
         S_OB: begin
            w_raddr = WA_W'(OFS_B1);
            state_in = S_OBL;
         end
         S_OBL: begin
            acc_in = ACC_W'(w_rd_ff);
            j_in = '0;
            state_in = S_OR;
         end
         S_OR: begin
            w_raddr = WA_W'(OFS_W1) + WA_W'(j_ff);
            state_in = S_OM;
         end
         S_OM: begin
            mul_a = h_ff[hx];
            mul_b = w_rd_ff;
            acc_in = acc_ff + ACC_W'(prod);
            if (j_ff == HI_W'(HIDDEN - 1)) begin
               state_in = S_OS;
            end else begin
               j_in = j_ff + 1'b1;
               state_in = S_OR;
            end
         end
         S_OS: begin
            if (!p_ff) begin
               oa_in = sig_lookup(acc_ff);
               case (mode_ff)
                  MODE_POINT: state_in = S_CP;
                  MODE_PAIR: begin
                     if (la_ff != lb_ff) begin
                        p_in = 1'b1;
                        i_in = '0;
                        state_in = S_PRD;
                     end else begin
                        finish = 1'b1;
                     end
                  end
                  default: finish = 1'b1;
               endcase
            end else begin
               ob_in = sig_lookup(acc_ff);
               state_in = S_CR;
            end
         end
         S_CP: begin
            mul_a = q_type'({3'b000, oa_ff}) - (la_ff ? QONE : 16'sd0);
            mul_b = q_type'({1'b0, cw_ff});
            c_in = prod;
            train_in = 1'b1;
            p_in = 1'b0;
            state_in = S_D1A;
         end
         S_CR: begin
            c_in = q_type'({3'b000, sig_lookup(ACC_W'(q_type'({3'b000, oa_ff}))
                                              - ACC_W'(q_type'({3'b000, ob_ff})))})
                   - (la_ff ? QONE : 16'sd0);
            train_in = 1'b1;
            p_in = 1'b0;
            state_in = S_D1A;
         end
         S_D1A: begin
            mul_a = q_type'({3'b000, p_ff ? ob_ff : oa_ff});
            mul_b = QONE - mul_a;
            t_in = prod;
            state_in = S_D1B;
         end
         S_D1B: begin
            mul_a = c_ff;
            mul_b = t_ff;
            delta1_in = prod;
            j_in = '0;
            state_in = S_D0R;
         end
         S_D0R: begin
            w_raddr = WA_W'(OFS_W1) + WA_W'(j_ff);
            mul_a = h_ff[hx];
            mul_b = QONE - h_ff[hx];
            t_in = prod;
            state_in = S_D0A;
         end
         S_D0A: begin
            mul_a = w_rd_ff;
            mul_b = t_ff;
            t_in = prod;
            state_in = S_D0B;
         end
         S_D0B: begin
            mul_a = delta1_ff;
            mul_b = t_ff;
            d0_we = 1'b1;
            if (j_ff == HI_W'(HIDDEN - 1)) begin
               nph_in = NPH_B1;
               state_in = S_NR;
            end else begin
               j_in = j_ff + 1'b1;
               state_in = S_D0R;
            end
         end
         S_NR: begin
            case (nph_ff)
               NPH_B1: begin
                  w_raddr = WA_W'(OFS_B1);
                  d_in = delta1_ff;
               end
               NPH_W1: begin
                  w_raddr = WA_W'(OFS_W1) + WA_W'(j_ff);
                  mul_a = h_ff[hx];
                  mul_b = delta1_ff;
                  d_in = prod;
               end
               NPH_B0: begin
                  w_raddr = WA_W'(OFS_B0) + WA_W'(j_ff);
                  d_in = d0_ff[j_ff];
               end
               NPH_W0: begin
                  w_raddr = WA_W'(i_ff) * WA_W'(HIDDEN) + WA_W'(j_ff);
                  mul_a = x_ff[fx];
                  mul_b = d0_ff[j_ff];
                  d_in = prod;
               end
               default: ;
            endcase
            state_in = S_NW;
         end
         S_NW: begin
            // pass A descends the gradient, pass B climbs it
            nsum = p_ff ? 17'(w_rd_ff) + 17'(d_ff) : 17'(w_rd_ff) - 17'(d_ff);
            nv = sat16(40'(nsum));
            w_we = 1'b1;
            w_wdata = nv;
            if (nv != w_rd_ff) changed_in = 1'b1;
            state_in = S_NR;
            case (nph_ff)
               NPH_B1: begin
                  nph_in = NPH_W1;
                  j_in = '0;
               end
               NPH_W1: begin
                  if (j_ff == HI_W'(HIDDEN - 1)) begin
                     nph_in = NPH_B0;
                     j_in = '0;
                  end else begin
                     j_in = j_ff + 1'b1;
                  end
               end
               NPH_B0: begin
                  if (j_ff == HI_W'(HIDDEN - 1)) begin
                     nph_in = NPH_W0;
                     i_in = '0;
                     j_in = '0;
                  end else begin
                     j_in = j_ff + 1'b1;
                  end
               end
               NPH_W0: begin
                  if (j_ff == HI_W'(HIDDEN - 1)) begin
                     j_in = '0;
                     if (i_ff == FI_W'(FEATURES - 1)) begin
                        i_in = '0;
                        if (!p_ff && mode_ff == MODE_PAIR) begin
                           p_in = 1'b1;
                           state_in = S_D1A;
                        end else begin
                           finish = 1'b1;
                        end
                     end else begin
                        i_in = i_ff + 1'b1;
                     end
                  end else begin
                     j_in = j_ff + 1'b1;
                  end
               end
               default: ;
            endcase
         end
         default: state_in = S_IDLE;
      endcase

      if (finish) begin
         // drop back to idle and strobe the result
         state_in = S_IDLE;
         rsp_valid_in = 1'b1;
         rsp_score_in = oa_in;
         rsp_pred_in = (oa_in >= thr_ff);
         abs_c = (c_in == 16'sh8000) ? 16'sh7FFF : (c_in < 0 ? -c_in : c_in);
         rsp_cost_in = train_in ? abs_c[14:0] : 15'd0;
         rsp_upd_in = train_in & changed_in;
      end
   end

   // feature and weight memories, registered reads
   always_ff @(posedge clock) begin
      if (f_we) fmem[f_waddr] <= req_value;
      f_rd_ff <= fmem[f_raddr];
   end

   always_ff @(posedge clock) begin
      if (w_we) wmem[w_waddr] <= w_wdata;
      w_rd_ff <= wmem[w_raddr];
      waddr_ff <= w_raddr;
   end

   always_ff @(posedge clock) begin
      if (x_we) x_ff[fx] <= x_wdata;
      if (h_we) h_ff[hx] <= h_wdata;
      if (d0_we) d0_ff[j_ff] <= prod;
   end

   // normalization tables reset to min 0, scale one
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < FEATURES; k++) begin
            nmin_ff[k] <= '0;
            nrec_ff[k] <= QONE;
         end
      end else begin
         if (nmin_we) nmin_ff[req_index[FI_W-1:0]] <= req_value;
         if (nrec_we) nrec_ff[req_index[FI_W-1:0]] <= req_value;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= 13'd2048;
         norm_en_ff <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_THRESHOLD: thr_ff <= csr_wdata;
            CSR_NORM_EN:   norm_en_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      nph_ff <= nph_in;       mode_ff <= mode_in;     p_ff <= p_in;
      i_ff <= i_in;           j_ff <= j_in;           acc_ff <= acc_in;
      t_ff <= t_in;           d_ff <= d_in;           delta1_ff <= delta1_in;
      c_ff <= c_in;           oa_ff <= oa_in;         ob_ff <= ob_in;
      changed_ff <= changed_in; train_ff <= train_in;
      la_ff <= la_in;         lb_ff <= lb_in;         cw_ff <= cw_in;
      rsp_score_ff <= rsp_score_in; rsp_pred_ff <= rsp_pred_in;
      rsp_cost_ff <= rsp_cost_in;   rsp_upd_ff <= rsp_upd_in;
   end

   assign busy = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_score = rsp_score_ff;
   assign rsp_pred_class = rsp_pred_ff;
   assign rsp_abs_cost = rsp_cost_ff;
   assign rsp_updated = rsp_upd_ff;

   // a result always lands as the sequencer returns to idle
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("result while busy");

   // a weight can only move when the cost is nonzero
   a_upd_cost: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_updated |-> rsp_abs_cost != 15'd0) else $error("update with zero cost");

   a_score_rng: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_score <= 13'd4096) else $error("score out of range");

   // load words and the unused mode answer in the next cycle
   a_load_rsp: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_mode <= MODE_NSCALE || req_mode > MODE_PAIR)
      |=> rsp_valid && !busy) else $error("load result missing");

endmodule

// ----- tb/mlp_sigmoid_train_infer_top_tb.sv -----
`timescale 1ns / 1ps

module mlp_sigmoid_train_infer_top_tb
   import mst_pkg::*;
();

   // mode seven has no enum member: the block ignores it
   localparam logic [2:0] MODE_UNUSED = 3'd7;
   localparam int DRAIN_CYCLES = 8;
   localparam int PHASE_WORDS = 90;

   typedef struct packed {
      logic [2:0]         mode;
      logic               slot;
      logic [10:0]        index;
      logic signed [15:0] value;
      logic               label_a;
      logic               label_b;
      logic [14:0]        cost_weight;
   } word_type;

   typedef struct packed {
      logic [12:0] score;
      logic        pred_class;
      logic [14:0] abs_cost;
      logic        updated;
   } outcome_type;

   // directed row: typed = 1 means the expected outcome is written out in the row
   typedef struct packed {
      word_type    w;
      logic        typed;
      outcome_type outcome;
   } row_type;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [2:0]         req_mode;
   logic               req_slot;
   logic [10:0]        req_index;
   logic signed [15:0] req_value;
   logic               req_label_a;
   logic               req_label_b;
   logic [14:0]        req_cost_weight;
   logic               rsp_valid;
   logic [12:0]        rsp_score;
   logic               rsp_pred_class;
   logic [14:0]        rsp_abs_cost;
   logic               rsp_updated;
   logic               csr_valid;
   logic               csr_ready;
   logic               csr_index;
   logic [12:0]        csr_wdata;

   mlp_sigmoid_train_infer_top u_dut (.*);

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------------------------
   // Network shadow: its own copy of every memory and configuration register, in plain ints
   // ---------------------------------------------------------------------------------------
   int logistic_rom [256];
   int feat_mem [2*FEATURES];
   int weight_mem [NWEIGHTS];
   int nmin_mem [FEATURES];
   int nrecip_mem [FEATURES];
   int net_in [2][FEATURES];
   int net_hid [2][HIDDEN];
   int threshold_q;
   int norm_on;

   outcome_type expected_outcomes [$];
   int mismatches;
   int n_words, n_infer, n_point, n_pair, n_seen;

   function automatic void fill_logistic_rom();
      longint unsigned one, term, e, d, den, num, q, r;
      int n;
      one = 64'd1 << 40;
      for (int k = 0; k <= 128; k++) begin
         term = one;
         e = one;
         n = 1;
         while (term != 0) begin
            d = 64'd16 * n;
            term = (term / d) * k + ((term % d) * k) / d;
            e += term;
            n++;
         end
         den = e + one;
         num = 64'd4096 * e;
         q = num / den;
         r = num % den;
         if (2 * r >= den) q++;
         if (k < 128) logistic_rom[128 + k] = int'(q);
         if (k > 0) logistic_rom[128 - k] = 4096 - int'(q);
      end
   endfunction

   function automatic int clip16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return int'(v);
   endfunction

   function automatic int fxmul(int a, int b);
      longint p;
      p = longint'(a) * longint'(b);
      return clip16(p >>> 12);
   endfunction

   function automatic int squash(longint x);
      int c;
      c = clip16(x);
      return logistic_rom[(c >>> 8) + 128];
   endfunction

   function automatic void normalize_inputs(int s);
      int v;
      for (int i = 0; i < FEATURES; i++) begin
         v = feat_mem[s*FEATURES + i];
         if (norm_on != 0) v = fxmul(clip16(longint'(v) - nmin_mem[i]), nrecip_mem[i]);
         net_in[s][i] = v;
      end
   endfunction

   function automatic int run_forward(int s);
      longint acc;
      for (int j = 0; j < HIDDEN; j++) begin
         acc = weight_mem[OFS_B0 + j];
         for (int i = 0; i < FEATURES; i++)
            acc += fxmul(net_in[s][i], weight_mem[i*HIDDEN + j]);
         net_hid[s][j] = squash(acc);
      end
      acc = weight_mem[OFS_B1];
      for (int j = 0; j < HIDDEN; j++) acc += fxmul(net_hid[s][j], weight_mem[OFS_W1 + j]);
      return squash(acc);
   endfunction

   function automatic bit step_weight(int addr, int d, int sgn);
      int old;
      old = weight_mem[addr];
      weight_mem[addr] = clip16(longint'(old) + longint'(sgn) * d);
      return weight_mem[addr] != old;
   endfunction

   function automatic bit run_backward(int c, int sgn, int s, int o);
      int d0 [HIDDEN];
      int d1;
      bit chg;
      chg = 0;
      d1 = fxmul(c, fxmul(o, 4096 - o));
      // hidden deltas use w1 before it moves
      for (int j = 0; j < HIDDEN; j++)
         d0[j] = fxmul(d1, fxmul(weight_mem[OFS_W1 + j],
                                 fxmul(net_hid[s][j], 4096 - net_hid[s][j])));
      chg |= step_weight(OFS_B1, d1, sgn);
      for (int j = 0; j < HIDDEN; j++)
         chg |= step_weight(OFS_W1 + j, fxmul(net_hid[s][j], d1), sgn);
      for (int j = 0; j < HIDDEN; j++) chg |= step_weight(OFS_B0 + j, d0[j], sgn);
      for (int i = 0; i < FEATURES; i++)
         for (int j = 0; j < HIDDEN; j++)
            chg |= step_weight(i*HIDDEN + j, fxmul(net_in[s][i], d0[j]), sgn);
      return chg;
   endfunction

   function automatic outcome_type predict_outcome(word_type w);
      outcome_type res;
      int oa, ob, c, m;
      bit trained, chg;
      res = '0;
      c = 0;
      trained = 0;
      chg = 0;
      case (w.mode)
         MODE_FEATURE: if (w.index < FEATURES) feat_mem[w.slot*FEATURES + w.index] = w.value;
         MODE_WEIGHT:  if (w.index < NWEIGHTS) weight_mem[w.index] = w.value;
         MODE_NMIN:    if (w.index < FEATURES) nmin_mem[w.index] = w.value;
         MODE_NSCALE:  if (w.index < FEATURES) nrecip_mem[w.index] = w.value;
         MODE_INFER, MODE_POINT, MODE_PAIR: begin
            normalize_inputs(0);
            oa = run_forward(0);
            res.score = 13'(oa);
            res.pred_class = (oa >= threshold_q);
            if (w.mode == MODE_POINT) begin
               c = fxmul(oa - w.label_a * 4096, int'(w.cost_weight));
               trained = 1;
               chg = run_backward(c, -1, 0, oa);
            end else if (w.mode == MODE_PAIR && w.label_a != w.label_b) begin
               normalize_inputs(1);
               ob = run_forward(1);
               c = squash(longint'(oa) - ob) - w.label_a * 4096;
               trained = 1;
               chg = run_backward(c, -1, 0, oa);
               chg |= run_backward(c, 1, 1, ob);
            end
            if (trained) begin
               m = (c < 0) ? -c : c;
               res.abs_cost = 15'((m > 32767) ? 32767 : m);
               res.updated = chg;
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   // ---------------------------------------------------------------------------------------
   // Result checker: the strobe lasts one cycle, so sample every edge
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin
      outcome_type got, want;
      if (!reset && rsp_valid) begin
         got = '{rsp_score, rsp_pred_class, rsp_abs_cost, rsp_updated};
         n_seen++;
         if (expected_outcomes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result word: %p", got);
         end else begin
            want = expected_outcomes.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"result mismatch: score %0d/%0d class %0d/%0d",
                            " cost %0d/%0d upd %0d/%0d"},
                           want.score, got.score, want.pred_class, got.pred_class,
                           want.abs_cost, got.abs_cost, want.updated, got.updated);
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Word driver. Leave start high after acceptance so a back-to-back word needs only one
   // assignment; callers drop it through a gap or drain_results.
   // ---------------------------------------------------------------------------------------
   task automatic issue_word(word_type w, int gap, bit typed = 0,
                             outcome_type typed_out = '0);
      outcome_type pred;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start           <= 1'b1;
      req_mode        <= w.mode;
      req_slot        <= w.slot;
      req_index       <= w.index;
      req_value       <= w.value;
      req_label_a     <= w.label_a;
      req_label_b     <= w.label_b;
      req_cost_weight <= w.cost_weight;
      do @(posedge clock); while (busy);
      pred = predict_outcome(w);
      expected_outcomes.push_back(typed ? typed_out : pred);
      n_words++;
      if (w.mode == MODE_INFER) n_infer++;
      if (w.mode == MODE_POINT) n_point++;
      if (w.mode == MODE_PAIR) n_pair++;
   endtask

   // hold off until every expected word is back and the block is quiet
   task automatic drain_results();
      start <= 1'b0;
      do @(posedge clock); while (expected_outcomes.size() != 0 || busy);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [12:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_THRESHOLD) threshold_q = int'(data);
      else norm_on = int'(data[0]);
   endtask

   task automatic configure(logic [12:0] thr, logic en);
      drain_results();
      write_csr(CSR_THRESHOLD, thr);
      write_csr(CSR_NORM_EN, {12'd0, en});
   endtask

   function automatic logic signed [15:0] rand_q();
      // mostly moderate values so the sigmoid stays off its rails, sometimes anything
      if ($urandom_range(0, 9) == 0) return 16'($urandom);
      return 16'($urandom_range(0, 12287)) - 16'sd6144;
   endfunction

   function automatic word_type rand_word();
      word_type w;
      int pick;
      w.slot        = 1'($urandom_range(0, 1));
      w.value       = rand_q();
      w.label_a     = 1'($urandom_range(0, 1));
      w.label_b     = 1'($urandom_range(0, 1));
      w.cost_weight = ($urandom_range(0, 3) == 0) ? 15'($urandom)
                                                  : 15'($urandom_range(0, 8192));
      pick = $urandom_range(0, 99);
      if (pick < 22) begin
         w.mode = MODE_FEATURE;
         w.index = 11'($urandom_range(0, FEATURES - 1));
      end else if (pick < 44) begin
         w.mode = MODE_WEIGHT;
         w.index = 11'($urandom_range(0, NWEIGHTS - 1));
      end else if (pick < 50) begin
         w.mode = MODE_NMIN;
         w.index = 11'($urandom_range(0, FEATURES - 1));
      end else if (pick < 56) begin
         w.mode = MODE_NSCALE;
         w.index = 11'($urandom_range(0, FEATURES - 1));
         if ($urandom_range(0, 2) != 0) w.value = 16'($urandom_range(2048, 6144));
      end else if (pick < 62) begin
         // ignored words: bad index on a load, or the unused mode
         w.mode = ($urandom_range(0, 4) == 0) ? MODE_UNUSED : 3'($urandom_range(0, 3));
         w.index = 11'($urandom_range(NWEIGHTS, 2047));
      end else if (pick < 74) begin
         w.mode = MODE_INFER;
         w.index = 11'($urandom);
      end else if (pick < 88) begin
         w.mode = MODE_POINT;
         w.index = 11'($urandom);
      end else begin
         w.mode = MODE_PAIR;
         w.index = 11'($urandom);
      end
      return w;
   endfunction

   function automatic int rand_gap(bit quiet);
      if (quiet || $urandom_range(0, 3) != 0) return 0;
      return $urandom_range(1, 16);
   endfunction

   // directed rows, walked after every store has been filled
   localparam outcome_type ZERO = '0;
   localparam int NROWS = 20;
   row_type rows [NROWS] = '{
      '{'{MODE_INFER,   1'b0, 11'd0,    16'sd0,      1'b0, 1'b0, 15'd4096},  1'b0, ZERO},
      '{'{MODE_UNUSED,  1'b1, 11'd2047, -16'sd1,     1'b1, 1'b1, 15'd32767}, 1'b1, ZERO},
      '{'{MODE_WEIGHT,  1'b0, 11'd2047, -16'sd32768, 1'b0, 1'b0, 15'd0},     1'b1, ZERO},
      '{'{MODE_WEIGHT,  1'b0, 11'd289,  16'sd32767,  1'b0, 1'b0, 15'd0},     1'b1, ZERO},
      '{'{MODE_FEATURE, 1'b1, 11'd16,   16'sd32767,  1'b0, 1'b0, 15'd0},     1'b1, ZERO},
      '{'{MODE_NMIN,    1'b0, 11'd16,   16'sd100,    1'b0, 1'b0, 15'd0},     1'b1, ZERO},
      '{'{MODE_NSCALE,  1'b0, 11'd2047, 16'sd0,      1'b0, 1'b0, 15'd0},     1'b1, ZERO},
      '{'{MODE_POINT,   1'b0, 11'd0,    16'sd0,      1'b0, 1'b0, 15'd0},     1'b0, ZERO},
      '{'{MODE_POINT,   1'b0, 11'd0,    16'sd0,      1'b1, 1'b0, 15'd32767}, 1'b0, ZERO},
      '{'{MODE_PAIR,    1'b0, 11'd0,    16'sd0,      1'b1, 1'b1, 15'd0},     1'b0, ZERO},
      '{'{MODE_PAIR,    1'b0, 11'd0,    16'sd0,      1'b1, 1'b0, 15'd0},     1'b0, ZERO},
      '{'{MODE_PAIR,    1'b0, 11'd0,    16'sd0,      1'b0, 1'b1, 15'd0},     1'b0, ZERO},
      '{'{MODE_FEATURE, 1'b0, 11'd0,    16'sd32767,  1'b0, 1'b0, 15'd0},     1'b1, ZERO},
      '{'{MODE_FEATURE, 1'b0, 11'd15,   -16'sd32768, 1'b0, 1'b0, 15'd0},     1'b1, ZERO},
      '{'{MODE_NMIN,    1'b0, 11'd15,   16'sd32767,  1'b0, 1'b0, 15'd0},     1'b1, ZERO},
      '{'{MODE_NSCALE,  1'b0, 11'd0,    -16'sd32768, 1'b0, 1'b0, 15'd0},     1'b1, ZERO},
      '{'{MODE_WEIGHT,  1'b0, 11'd288,  16'sd32767,  1'b0, 1'b0, 15'd0},     1'b1, ZERO},
      '{'{MODE_WEIGHT,  1'b0, 11'd0,    -16'sd32768, 1'b0, 1'b0, 15'd0},     1'b1, ZERO},
      '{'{MODE_INFER,   1'b0, 11'd0,    16'sd0,      1'b0, 1'b0, 15'd0},     1'b0, ZERO},
      '{'{MODE_POINT,   1'b0, 11'd0,    16'sd0,      1'b0, 1'b0, 15'd4096},  1'b0, ZERO}
   };

   // ---------------------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------------------
   initial begin
      word_type w;
      clock = 1'b0;
      reset <= 1'b1;
      start <= 1'b0;
      req_mode <= MODE_FEATURE;
      req_slot <= 1'b0;
      req_index <= '0;
      req_value <= '0;
      req_label_a <= 1'b0;
      req_label_b <= 1'b0;
      req_cost_weight <= '0;
      csr_valid <= 1'b0;
      csr_index <= CSR_THRESHOLD;
      csr_wdata <= '0;
      mismatches = 0;
      n_words = 0;
      n_infer = 0;
      n_point = 0;
      n_pair = 0;
      n_seen = 0;
      fill_logistic_rom();
      foreach (feat_mem[i]) feat_mem[i] = 0;
      foreach (weight_mem[i]) weight_mem[i] = 0;
      foreach (nmin_mem[i]) nmin_mem[i] = 0;
      foreach (nrecip_mem[i]) nrecip_mem[i] = 4096;
      threshold_q = 2048;
      norm_on = 1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // fill both feature buffers and every weight so nothing unwritten is ever read
      for (int s = 0; s < 2; s++)
         for (int i = 0; i < FEATURES; i++) begin
            w = '{MODE_FEATURE, 1'(s), 11'(i), rand_q(), 1'b0, 1'b0, 15'd0};
            issue_word(w, rand_gap(0));
         end
      for (int i = 0; i < NWEIGHTS; i++) begin
         w = '{MODE_WEIGHT, 1'b0, 11'(i), 16'($urandom_range(0, 4095)) - 16'sd2048,
               1'b0, 1'b0, 15'd0};
         issue_word(w, rand_gap(0));
      end

      // directed rows under the reset settings
      foreach (rows[r]) issue_word(rows[r].w, rand_gap(0), rows[r].typed, rows[r].outcome);

      // random phases, each under its own register settings; reseed the weights once so
      // the saturated directed extremes do not dominate
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: configure(13'd0, 1'b0);
            1: configure(13'd4096, 1'b1);
            2: configure(13'($urandom_range(0, 4096)), 1'($urandom));
            default: configure(13'd2048, 1'b1);
         endcase
         if (ph == 0) begin
            for (int i = 0; i < NWEIGHTS; i++) begin
               w = '{MODE_WEIGHT, 1'b0, 11'(i), 16'($urandom_range(0, 4095)) - 16'sd2048,
                     1'b0, 1'b0, 15'd0};
               issue_word(w, 0);
            end
         end
         for (int k = 0; k < PHASE_WORDS; k++) begin
            // midway through the second phase, hold off until everything outstanding has come back
            if (ph == 1 && k == PHASE_WORDS / 2) drain_results();
            issue_word(rand_word(), rand_gap(ph == 3));
         end
      end

      start <= 1'b0;
      do @(posedge clock); while (expected_outcomes.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d words: %0d inferences, %0d point and %0d pair trainings, %0d results",
               n_words, n_infer, n_point, n_pair, n_seen);
      $display("threshold and normalize settings swept over four phases, mismatches: %0d",
               mismatches);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // watchdog
   initial begin
      #60_000_000;
      $display("timeout with %0d results outstanding", expected_outcomes.size());
      $display("end of test: mismatches");
      $finish;
   end

endmodule
